// ----- rtl/core/cppd_pkg.sv -----
// ---------------------------------------------------------------------------
// cppd_pkg: shared types, constants and helpers
// Fixed-point formats, built-in rigid transform, register indexes and the
// saturating add used throughout the projection pipeline.
// ---------------------------------------------------------------------------
package cppd_pkg;

  localparam int FRAC    = 28;   // fraction bits of normalized values
  localparam int PT_W    = 32;   // point coordinate, Q20.12
  localparam int PIX_W   = 32;   // pixel coordinate, Q16.16
  localparam int VAL_W   = 63;   // working value, |v| <= 2^62 - 1
  localparam int PROD_W  = 62;   // rotation product
  localparam int ACC_W   = 63;   // transform accumulator
  localparam int DEPTH_W = 33;   // transformed coordinate, Q.12
  localparam int ZMAG_W  = 32;   // magnitude of a transformed coordinate
  localparam int DIV_W   = 61;   // quotient bits of the perspective divide
  localparam int RSH     = 30;   // fraction bits of the rotation matrix
  localparam int D_LAT   = 20;   // distortion pipeline depth

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t LIM = val_t'(64'h3FFF_FFFF_FFFF_FFFF);
  localparam val_t ONE = val_t'(64'd1 << FRAC);

  // rotation, Q.30, rounded to nearest
  localparam longint R00 = (longint'(956707) * 1073741824 + 500000) / 1000000;
  localparam longint R01 = (longint'(5870)   * 1073741824 + 500000) / 1000000;
  localparam longint R02 = (longint'(290994) * 1073741824 + 500000) / 1000000;
  localparam longint R10 = (longint'(66042)  * 1073741824 + 500000) / 1000000;
  localparam longint R11 = (longint'(978096) * 1073741824 + 500000) / 1000000;
  localparam longint R12 = (longint'(197398) * 1073741824 + 500000) / 1000000;
  localparam longint R20 = (longint'(283462) * 1073741824 + 500000) / 1000000;
  localparam longint R21 = (longint'(208069) * 1073741824 + 500000) / 1000000;
  localparam longint R22 = (longint'(936139) * 1073741824 + 500000) / 1000000;

  localparam logic signed [31:0] ROT [0:8] = '{
    32'(R00), -32'(R01), -32'(R02),
    32'(R10),  32'(R11),  32'(R12),
    32'(R20), -32'(R21),  32'(R22)
  };

  // translation, Q.12, rounded to nearest
  localparam longint T0 = (longint'(8121237)  * 4096 + 50000) / 100000;
  localparam longint T1 = (longint'(18571510) * 4096 + 50000) / 100000;
  localparam longint T2 = (longint'(560391)   * 4096 + 50000) / 100000;

  localparam longint TRANS [0:2] = '{T0, -T1, -T2};

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FOCAL_X = 3'd0,
    REG_FOCAL_Y = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1 = 3'd4,
    REG_K2 = 3'd5,
    REG_P1 = 3'd6,
    REG_P2 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]        focal_x;
    logic [30:0]        focal_y;
    logic [30:0]        center_x;
    logic [30:0]        center_y;
    logic signed [31:0] radial_k1;
    logic signed [31:0] radial_k2;
    logic signed [31:0] tangential_p1;
    logic signed [31:0] tangential_p2;
  } cfg_t;

  // control that travels with each request
  typedef struct packed {
    logic valid;
    logic behind;
  } tag_t;

  // a + b, clamped to +-LIM
  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] hi;
    s  = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
    hi = $signed({1'b0, LIM});
    if (s > hi) return LIM;
    else if (s < -hi) return -LIM;
    else return val_t'(s[VAL_W-1:0]);
  endfunction

  // unsigned config value to working value
  function automatic val_t from_u31(logic [30:0] v);
    return val_t'({32'd0, v});
  endfunction

  // signed config value to working value
  function automatic val_t from_s32(logic signed [31:0] v);
    return val_t'({{(VAL_W-32){v[31]}}, v});
  endfunction

endpackage

// ----- rtl/core/camera_point_projection_distortion_unit.sv -----
// ---------------------------------------------------------------------------
// camera_point_projection_distortion_unit: point to pixel projection
// Rigid transform, perspective divide, lens distortion and pixel mapping.
// ---------------------------------------------------------------------------
// Accepts one 3D point per clock while in_tready is high and returns one pixel
// request per point, in order. The path holds 87 register stages: 3 for the
// transform, 63 for the perspective divide (one quotient bit per stage, 61
// stages plus operand prep and sign), 20 for the distortion chain of five
// 3-stage multiply banks, and 1 output register. The first stage loads at the
// accepting edge. The pipeline halts as a whole only when the output register
// is full and not taken while another result is ready behind it. Points with
// depth not positive come out with behind_camera set and both pixels zero.
// Write the configuration registers only while no request is in flight.
module camera_point_projection_distortion_unit (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: point_x[31:0], point_y[63:32], point_z[95:64]
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pixel_u[31:0], pixel_v[63:32]
  output logic [63:0] out_tdata,
  // tuser: behind_camera[0]
  output logic [0:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import cppd_pkg::*;

  cfg_t cfg_r;
  logic en;

  tag_t                      xf_tag, dv_tag, ds_tag;
  logic signed [DEPTH_W-1:0] xf_x, xf_y, xf_z;
  val_t                      xn, yn;
  logic signed [PIX_W-1:0]   pu, pv;

  logic                      out_valid_r;
  logic [PIX_W-1:0]          u_r, v_r;
  logic                      behind_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x       <= 31'd238736272;
      cfg_r.focal_y       <= 31'd238954084;
      cfg_r.center_x      <= 31'd109740933;
      cfg_r.center_y      <= 31'd85745808;
      cfg_r.radial_k1     <= -32'sd32928977;
      cfg_r.radial_k2     <= 32'sd109666621;
      cfg_r.tangential_p1 <= 32'sd1970316;
      cfg_r.tangential_p2 <= 32'sd260382;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FOCAL_X:  cfg_r.focal_x       <= cfg_wdata[30:0];
        REG_FOCAL_Y:  cfg_r.focal_y       <= cfg_wdata[30:0];
        REG_CENTER_X: cfg_r.center_x      <= cfg_wdata[30:0];
        REG_CENTER_Y: cfg_r.center_y      <= cfg_wdata[30:0];
        REG_K1:       cfg_r.radial_k1     <= $signed(cfg_wdata);
        REG_K2:       cfg_r.radial_k2     <= $signed(cfg_wdata);
        REG_P1:       cfg_r.tangential_p1 <= $signed(cfg_wdata);
        REG_P2:       cfg_r.tangential_p2 <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // advance unless a finished result would collide with a held output
  assign en        = !(out_valid_r && !out_tready && ds_tag.valid);
  assign in_tready = en;

  cppd_xform u_xform (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_tvalid),
    .px_i($signed(in_tdata[31:0])),
    .py_i($signed(in_tdata[63:32])),
    .pz_i($signed(in_tdata[95:64])),
    .tag_o(xf_tag), .x_o(xf_x), .y_o(xf_y), .z_o(xf_z)
  );

  cppd_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .tag_i(xf_tag), .x_i(xf_x), .y_i(xf_y), .z_i(xf_z),
    .tag_o(dv_tag), .xn_o(xn), .yn_o(yn)
  );

  cppd_distort u_distort (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg_i(cfg_r),
    .tag_i(dv_tag), .xn_i(xn), .yn_i(yn),
    .tag_o(ds_tag), .u_o(pu), .v_o(pv)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= ds_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      u_r      <= pu;
      v_r      <= pv;
      behind_r <= ds_tag.behind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {v_r, u_r};
  assign out_tuser  = behind_r;

endmodule

// ----- rtl/core/cppd_mulq.sv -----
// ---------------------------------------------------------------------------
// cppd_mulq: pipelined fractional multiply
// round(a * b / 2^28), ties away from zero, clamped to +-(2^62 - 1).
// Three stages: 32-bit partial products, product sum, round and clamp.
// ---------------------------------------------------------------------------
module cppd_mulq (
  input  logic           clk,
  input  logic           en,
  input  cppd_pkg::val_t a_i,
  input  cppd_pkg::val_t b_i,
  output cppd_pkg::val_t p_o
);
  import cppd_pkg::*;

  localparam int MAG_W = VAL_W - 1;
  localparam int SUM_W = 2 * MAG_W;
  localparam logic [SUM_W-FRAC-1:0] LIM_Q = (SUM_W-FRAC)'(LIM);

  logic [MAG_W-1:0] ua, ub;
  logic             neg;

  logic [63:0]      ll_r;
  logic [61:0]      lh_r, hl_r;
  logic [59:0]      hh_r;
  logic             neg1_r;

  logic [SUM_W-1:0] sum_r;
  logic             neg2_r;

  logic [SUM_W-FRAC-1:0] q;
  logic [MAG_W-1:0]      qm;
  val_t                  p_r;

  // magnitudes and result sign
  always_comb begin
    neg = a_i[VAL_W-1] ^ b_i[VAL_W-1];
    ua  = MAG_W'(a_i[VAL_W-1] ? -a_i : a_i);
    ub  = MAG_W'(b_i[VAL_W-1] ? -b_i : b_i);
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ua[31:0] * ub[31:0];
      lh_r   <= ua[31:0] * ub[MAG_W-1:32];
      hl_r   <= ua[MAG_W-1:32] * ub[31:0];
      hh_r   <= ua[MAG_W-1:32] * ub[MAG_W-1:32];
      neg1_r <= neg;
    end
  end

  // full product plus rounding half
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SUM_W'(ll_r) + (SUM_W'(lh_r) << 32) + (SUM_W'(hl_r) << 32)
             + (SUM_W'(hh_r) << 64) + (SUM_W'(1) << (FRAC - 1));
      neg2_r <= neg1_r;
    end
  end

  // scale, clamp, sign
  always_comb begin
    q  = sum_r[SUM_W-1:FRAC];
    qm = (q > LIM_Q) ? MAG_W'(LIM) : q[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg2_r ? -val_t'({1'b0, qm}) : val_t'({1'b0, qm});
    end
  end

  assign p_o = p_r;

endmodule

// ----- rtl/core/cppd_xform.sv -----
// ---------------------------------------------------------------------------
// cppd_xform: rigid transform into the target camera frame
// Three stages: nine constant products, row sums plus translation, and
// rounding to Q.12 with the depth sign check.
// ---------------------------------------------------------------------------
module cppd_xform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  valid_i,
  input  logic signed [cppd_pkg::PT_W-1:0]      px_i,
  input  logic signed [cppd_pkg::PT_W-1:0]      py_i,
  input  logic signed [cppd_pkg::PT_W-1:0]      pz_i,
  output cppd_pkg::tag_t                        tag_o,
  output logic signed [cppd_pkg::DEPTH_W-1:0]   x_o,
  output logic signed [cppd_pkg::DEPTH_W-1:0]   y_o,
  output logic signed [cppd_pkg::DEPTH_W-1:0]   z_o
);
  import cppd_pkg::*;

  logic signed [PT_W-1:0]    pt [0:2];
  logic signed [PROD_W-1:0]  prod_r [0:8];
  logic signed [ACC_W-1:0]   acc_r [0:2];
  logic [ACC_W-2:0]          am [0:2];
  logic [DEPTH_W-1:0]        qm [0:2];
  logic signed [DEPTH_W-1:0] q_nxt [0:2];
  logic signed [DEPTH_W-1:0] q_r [0:2];
  logic [2:0]                vld_r;
  logic                      behind_r;

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= PROD_W'(pt[i % 3] * ROT[i]);
      end
    end
  end

  // stage 2: row sums with translation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= ACC_W'(prod_r[3*r]) + ACC_W'(prod_r[3*r+1]) + ACC_W'(prod_r[3*r+2])
                  + ACC_W'(TRANS[r] <<< RSH);
      end
    end
  end

  // stage 3: round to Q.12, ties away from zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      am[r]    = (ACC_W-1)'(acc_r[r][ACC_W-1] ? -acc_r[r] : acc_r[r]);
      qm[r]    = DEPTH_W'(am[r][ACC_W-2:RSH]) + DEPTH_W'(am[r][RSH-1]);
      q_nxt[r] = acc_r[r][ACC_W-1] ? -$signed(qm[r]) : $signed(qm[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        q_r[r] <= q_nxt[r];
      end
      behind_r <= (q_nxt[2] <= 0);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  assign tag_o = '{valid: vld_r[2], behind: behind_r};
  assign x_o   = q_r[0];
  assign y_o   = q_r[1];
  assign z_o   = q_r[2];

endmodule

// ----- rtl/core/cppd_div.sv -----
// ---------------------------------------------------------------------------
// cppd_div: pipelined perspective divide
// xn = round(X * 2^28 / Z), yn likewise, one restoring quotient bit per
// stage for both coordinates against the shared depth.
// ---------------------------------------------------------------------------
module cppd_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  cppd_pkg::tag_t                      tag_i,
  input  logic signed [cppd_pkg::DEPTH_W-1:0] x_i,
  input  logic signed [cppd_pkg::DEPTH_W-1:0] y_i,
  input  logic signed [cppd_pkg::DEPTH_W-1:0] z_i,
  output cppd_pkg::tag_t                      tag_o,
  output cppd_pkg::val_t                      xn_o,
  output cppd_pkg::val_t                      yn_o
);
  import cppd_pkg::*;

  logic [DIV_W-1:0]  nx_r [0:DIV_W];
  logic [DIV_W-1:0]  ny_r [0:DIV_W];
  logic [ZMAG_W-1:0] rx_r [0:DIV_W-1];
  logic [ZMAG_W-1:0] ry_r [0:DIV_W-1];
  logic [ZMAG_W-1:0] z_r  [0:DIV_W-1];
  logic              sx_r [0:DIV_W];
  logic              sy_r [0:DIV_W];
  logic              bh_r [0:DIV_W+1];
  logic [DIV_W+1:0]  vld_r;
  logic [ZMAG_W-1:0] xm, ym, zm;
  val_t              xn_r, yn_r;

  // operand magnitudes
  always_comb begin
    xm = ZMAG_W'(x_i[DEPTH_W-1] ? -x_i : x_i);
    ym = ZMAG_W'(y_i[DEPTH_W-1] ? -y_i : y_i);
    zm = z_i[ZMAG_W-1:0];
  end

  // prep: scaled numerator plus half divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      nx_r[0] <= DIV_W'({xm, FRAC'(0)}) + DIV_W'(zm[ZMAG_W-1:1]);
      ny_r[0] <= DIV_W'({ym, FRAC'(0)}) + DIV_W'(zm[ZMAG_W-1:1]);
      rx_r[0] <= '0;
      ry_r[0] <= '0;
      z_r[0]  <= zm;
      sx_r[0] <= x_i[DEPTH_W-1];
      sy_r[0] <= y_i[DEPTH_W-1];
      bh_r[0] <= tag_i.behind;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic [ZMAG_W:0] tx, ty;
    logic            gx, gy;

    always_comb begin
      tx = {rx_r[k], nx_r[k][DIV_W-1]};
      ty = {ry_r[k], ny_r[k][DIV_W-1]};
      gx = (tx >= {1'b0, z_r[k]});
      gy = (ty >= {1'b0, z_r[k]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[k+1] <= {nx_r[k][DIV_W-2:0], gx};
        ny_r[k+1] <= {ny_r[k][DIV_W-2:0], gy};
        sx_r[k+1] <= sx_r[k];
        sy_r[k+1] <= sy_r[k];
        bh_r[k+1] <= bh_r[k];
      end
    end

    // partial remainder and divisor, not needed past the last bit
    if (k < DIV_W-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rx_r[k+1] <= gx ? ZMAG_W'(tx - {1'b0, z_r[k]}) : tx[ZMAG_W-1:0];
          ry_r[k+1] <= gy ? ZMAG_W'(ty - {1'b0, z_r[k]}) : ty[ZMAG_W-1:0];
          z_r[k+1]  <= z_r[k];
        end
      end
    end
  end

  // signed quotients
  always_ff @(posedge clk) begin
    if (en) begin
      xn_r <= sx_r[DIV_W] ? -val_t'(nx_r[DIV_W]) : val_t'(nx_r[DIV_W]);
      yn_r <= sy_r[DIV_W] ? -val_t'(ny_r[DIV_W]) : val_t'(ny_r[DIV_W]);
      bh_r[DIV_W+1] <= bh_r[DIV_W];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_W:0], tag_i.valid};
    end
  end

  assign tag_o = '{valid: vld_r[DIV_W+1], behind: bh_r[DIV_W+1]};
  assign xn_o  = xn_r;
  assign yn_o  = yn_r;

endmodule

// ----- rtl/core/cppd_distort.sv -----
// ---------------------------------------------------------------------------
// cppd_distort: lens distortion and pixel mapping
// Radial and tangential distortion of the normalized point, focal scaling
// and principal point offset, clamped to Q16.16 pixels. 20 stages.
// ---------------------------------------------------------------------------
module cppd_distort (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  cppd_pkg::cfg_t                    cfg_i,
  input  cppd_pkg::tag_t                    tag_i,
  input  cppd_pkg::val_t                    xn_i,
  input  cppd_pkg::val_t                    yn_i,
  output cppd_pkg::tag_t                    tag_o,
  output logic signed [cppd_pkg::PIX_W-1:0] u_o,
  output logic signed [cppd_pkg::PIX_W-1:0] v_o
);
  import cppd_pkg::*;

  localparam val_t PIX_MAX = val_t'(64'sd2147483647);
  localparam val_t PIX_MIN = -val_t'(64'sd2147483648);

  logic [D_LAT:1] vld_r;
  logic           bh_r [1:D_LAT];

  val_t x2, y2, xy;
  val_t r2_4_r, xx_4_r, yy_4_r, xy_4_r;
  val_t r2_5_r, xy_5_r, r2x_5_r, r2y_5_r;
  val_t r4, k1r2, t1, t2, tx, ty, k2r4;
  val_t c0_r [9:11];
  val_t dx_r [9:15];
  val_t dy_r [9:15];
  val_t c_12_r;
  val_t xn_r [1:12];
  val_t yn_r [1:12];
  val_t cx, cy;
  val_t xd_16_r, yd_16_r;
  val_t fx, fy;
  val_t u, v;
  logic signed [PIX_W-1:0] u_r, v_r;

  // normalized squares and cross term
  cppd_mulq u_m_x2 (.clk(clk), .en(en), .a_i(xn_i), .b_i(xn_i), .p_o(x2));
  cppd_mulq u_m_y2 (.clk(clk), .en(en), .a_i(yn_i), .b_i(yn_i), .p_o(y2));
  cppd_mulq u_m_xy (.clk(clk), .en(en), .a_i(xn_i), .b_i(yn_i), .p_o(xy));

  // r2 and the doubled squares
  always_ff @(posedge clk) begin
    if (en) begin
      r2_4_r <= sat_add(x2, y2);
      xx_4_r <= sat_add(x2, x2);
      yy_4_r <= sat_add(y2, y2);
      xy_4_r <= xy;
    end
  end

  // tangential arguments
  always_ff @(posedge clk) begin
    if (en) begin
      r2x_5_r <= sat_add(r2_4_r, xx_4_r);
      r2y_5_r <= sat_add(r2_4_r, yy_4_r);
      r2_5_r  <= r2_4_r;
      xy_5_r  <= xy_4_r;
    end
  end

  // second product bank
  cppd_mulq u_m_r4 (.clk(clk), .en(en), .a_i(r2_5_r), .b_i(r2_5_r), .p_o(r4));
  cppd_mulq u_m_k1 (.clk(clk), .en(en), .a_i(from_s32(cfg_i.radial_k1)), .b_i(r2_5_r),
                    .p_o(k1r2));
  cppd_mulq u_m_t1 (.clk(clk), .en(en), .a_i(from_s32(cfg_i.tangential_p1)), .b_i(xy_5_r),
                    .p_o(t1));
  cppd_mulq u_m_t2 (.clk(clk), .en(en), .a_i(from_s32(cfg_i.tangential_p2)), .b_i(xy_5_r),
                    .p_o(t2));
  cppd_mulq u_m_tx (.clk(clk), .en(en), .a_i(from_s32(cfg_i.tangential_p2)), .b_i(r2x_5_r),
                    .p_o(tx));
  cppd_mulq u_m_ty (.clk(clk), .en(en), .a_i(from_s32(cfg_i.tangential_p1)), .b_i(r2y_5_r),
                    .p_o(ty));

  // k2 * r4
  cppd_mulq u_m_k2 (.clk(clk), .en(en), .a_i(from_s32(cfg_i.radial_k2)), .b_i(r4),
                    .p_o(k2r4));

  // partial radial gain and tangential offsets, then delay
  always_ff @(posedge clk) begin
    if (en) begin
      c0_r[9] <= sat_add(ONE, k1r2);
      dx_r[9] <= sat_add(sat_add(t1, t1), tx);
      dy_r[9] <= sat_add(ty, sat_add(t2, t2));
      for (int i = 10; i <= 11; i++) begin
        c0_r[i] <= c0_r[i-1];
      end
      for (int i = 10; i <= 15; i++) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
      end
    end
  end

  // full radial gain
  always_ff @(posedge clk) begin
    if (en) begin
      c_12_r <= sat_add(c0_r[11], k2r4);
    end
  end

  // normalized point delay to the gain multiply
  always_ff @(posedge clk) begin
    if (en) begin
      xn_r[1] <= xn_i;
      yn_r[1] <= yn_i;
      for (int i = 2; i <= 12; i++) begin
        xn_r[i] <= xn_r[i-1];
        yn_r[i] <= yn_r[i-1];
      end
    end
  end

  cppd_mulq u_m_cx (.clk(clk), .en(en), .a_i(c_12_r), .b_i(xn_r[12]), .p_o(cx));
  cppd_mulq u_m_cy (.clk(clk), .en(en), .a_i(c_12_r), .b_i(yn_r[12]), .p_o(cy));

  // distorted point
  always_ff @(posedge clk) begin
    if (en) begin
      xd_16_r <= sat_add(cx, dx_r[15]);
      yd_16_r <= sat_add(cy, dy_r[15]);
    end
  end

  cppd_mulq u_m_fx (.clk(clk), .en(en), .a_i(from_u31(cfg_i.focal_x)), .b_i(xd_16_r),
                    .p_o(fx));
  cppd_mulq u_m_fy (.clk(clk), .en(en), .a_i(from_u31(cfg_i.focal_y)), .b_i(yd_16_r),
                    .p_o(fy));

  // principal point offset and pixel clamp
  always_comb begin
    u = sat_add(fx, from_u31(cfg_i.center_x));
    v = sat_add(fy, from_u31(cfg_i.center_y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (bh_r[D_LAT-1]) begin
        u_r <= '0;
        v_r <= '0;
      end else begin
        u_r <= (u > PIX_MAX) ? PIX_W'(PIX_MAX) : ((u < PIX_MIN) ? PIX_W'(PIX_MIN) : PIX_W'(u));
        v_r <= (v > PIX_MAX) ? PIX_W'(PIX_MAX) : ((v < PIX_MIN) ? PIX_W'(PIX_MIN) : PIX_W'(v));
      end
    end
  end

  // depth flag travels with the data
  always_ff @(posedge clk) begin
    if (en) begin
      bh_r[1] <= tag_i.behind;
      for (int i = 2; i <= D_LAT; i++) begin
        bh_r[i] <= bh_r[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[D_LAT-1:1], tag_i.valid};
    end
  end

  assign tag_o = '{valid: vld_r[D_LAT], behind: bh_r[D_LAT]};
  assign u_o   = u_r;
  assign v_o   = v_r;

endmodule

// ----- rtl/core/cppd_checker.sv -----
// ---------------------------------------------------------------------------
// cppd_checker: port-level checks for the projection unit
// Watches the result channel only; bound to the top level.
// ---------------------------------------------------------------------------
module cppd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a behind-camera result carries zero pixels
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 64'd0)
    else $error("behind-camera result with nonzero pixels");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind camera_point_projection_distortion_unit cppd_checker u_cppd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
